/* design/skhf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skhf_pkg
// Shared types, constants and helpers of the scalar Kalman heading fuser.
// ----------------------------------------------------------------------------
package skhf_pkg;

  // field widths
  localparam int ANG_W   = 32;   // radians q.24, degrees q.16
  localparam int VAR_W   = 40;   // variance q.48
  localparam int K_W     = 25;   // gain q.24 in [0, 2^24]
  localparam int SUM_W   = 40;   // angle sums before saturation
  localparam int INC_W   = 39;   // rounded product after a 24 bit shift
  localparam int EMIT_W  = 31;   // rounded product after a 32 bit shift
  localparam int OPA_W   = 34;
  localparam int OPB_W   = 31;
  localparam int PROD_W  = 63;
  localparam int CFG_IDX_W = 1;

  // divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = K_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // fixed-point constants
  localparam logic [26:0]      DEG2RAD_Q32 = 27'd74961321;   // pi/180 * 2^32
  localparam logic [29:0]      RAD2DEG_Q24 = 30'd961263669;  // 180/pi * 2^24
  localparam logic [K_W-1:0]   ONE_Q24     = 25'h1000000;
  localparam logic [VAR_W-1:0] VAR_MAX     = {VAR_W{1'b1}};
  localparam logic [VAR_W-1:0] MEAS_VAR_RST = 40'd281474977;
  localparam logic [VAR_W-1:0] PROC_VAR_RST = 40'd703687442;
  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] RND24 = PROD_W'(64'd1 << 23);
  localparam logic [PROD_W-1:0] RND32 = PROD_W'(64'd1 << 31);

  // function codes of an input item
  localparam logic FUNC_VISION = 1'b0;
  localparam logic FUNC_GYRO   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_G_MUL,
    ST_G_UPD,
    ST_V_INIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_A_MUL,
    ST_A_UPD,
    ST_HI_MUL,
    ST_LO_MUL,
    ST_VAR_UPD,
    ST_E_MUL,
    ST_EMIT
  } state_e;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_GYRO,
    MUL_ANGLE,
    MUL_HI,
    MUL_LO,
    MUL_EMIT
  } mul_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     init_load;
    logic     gyro_upd;
    logic     div_init;
    logic     div_step;
    logic     ang_upd;
    logic     hi_save;
    logic     var_upd;
    logic     out_load;
    mul_sel_e mul_sel;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_gyro;
    logic empty;
    logic initialised;
    logic div_last;
    logic out_free;
  } status_t;

  // saturate a wide signed angle sum to 32 bits
  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
    logic all_ones;
    logic all_zeros;
    all_ones  = &v[SUM_W-1:ANG_W-1];
    all_zeros = ~|v[SUM_W-1:ANG_W-1];
    if (all_ones || all_zeros) begin
      return v[ANG_W-1:0];
    end else if (v[SUM_W-1]) begin
      return ANG_MIN;
    end else begin
      return ANG_MAX;
    end
  endfunction

endpackage
`default_nettype wire

/* design/scalar_kalman_heading_fuser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_heading_fuser
// One-dimensional Kalman filter fusing vision heading with gyro increments.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid_i / in_stall_o carries one item per beat: a
//   vision measurement (func 0) or a gyro increment (func 1).
//   output channel out_valid_o / out_stall_i carries the filtered heading
//   in degrees and a flag telling which kind of item produced it.
//   config channel cfg_valid_i / cfg_ready_o writes meas_var (index 0) or
//   proc_var (index 1); it is always ready. The user must write it only
//   while idle; the block does not enforce this.
// Sequencing:
//   a vision update is dominated by the restoring divider for the gain;
//   the first vision item loads the estimate directly, ignored items go
//   back to idle from decode. one item is in flight at a time; the next
//   item is accepted as soon as the result sits in the output register.
// Reset clears the estimate, variance and initialised flag and loads the
// default variances. A stalled receiver holds the result in the output
// register; the controller waits before overwriting it.
// ----------------------------------------------------------------------------
module scalar_kalman_heading_fuser (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire                               func_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]  tag_x_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]  tag_y_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]  tag_z_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]  tag_angle_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]  gyro_delta_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [skhf_pkg::ANG_W-1:0] filtered_degrees_o,
  output logic                              from_gyro_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [skhf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [skhf_pkg::VAR_W-1:0]         cfg_data_i
);

  skhf_pkg::cmd_t    cmd;
  skhf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // controller
  skhf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  skhf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .func_i             (func_i),
    .tag_x_i            (tag_x_i),
    .tag_y_i            (tag_y_i),
    .tag_z_i            (tag_z_i),
    .tag_angle_i        (tag_angle_i),
    .gyro_delta_i       (gyro_delta_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .filtered_degrees_o (filtered_degrees_o),
    .from_gyro_o        (from_gyro_o)
  );

  // busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous item still in work");

  // result loaded only into a free output register
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten before taken");

  // gyro, division and vision variance updates only after initialisation
  a_var_upd_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.var_upd || cmd.div_init || cmd.gyro_upd) |-> status.initialised)
    else $error("filter update before initialisation");

  // last divider step is followed by the gain multiply
  a_div_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step && status.div_last) |=> (cmd.mul_sel == skhf_pkg::MUL_ANGLE))
    else $error("gain multiply does not follow division");

endmodule
`default_nettype wire

/* design/skhf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skhf_dp
// Datapath: input capture, filter state, config registers, restoring
// divider for the gain, one shared multiplier and the output register.
// ----------------------------------------------------------------------------
module skhf_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  skhf_pkg::cmd_t                        cmd_i,
  output skhf_pkg::status_t                     status_o,
  input  wire                                   cfg_we_i,
  input  wire [skhf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [skhf_pkg::VAR_W-1:0]             cfg_data_i,
  input  wire                                   func_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]      tag_x_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]      tag_y_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]      tag_z_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]      tag_angle_i,
  input  wire signed [skhf_pkg::ANG_W-1:0]      gyro_delta_i,
  input  wire                                   out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [skhf_pkg::ANG_W-1:0]     filtered_degrees_o,
  output logic                                  from_gyro_o
);

  localparam int ANG_W  = skhf_pkg::ANG_W;
  localparam int VAR_W  = skhf_pkg::VAR_W;
  localparam int K_W    = skhf_pkg::K_W;
  localparam int SUM_W  = skhf_pkg::SUM_W;
  localparam int INC_W  = skhf_pkg::INC_W;
  localparam int EMIT_W = skhf_pkg::EMIT_W;
  localparam int OPA_W  = skhf_pkg::OPA_W;
  localparam int OPB_W  = skhf_pkg::OPB_W;
  localparam int PROD_W = skhf_pkg::PROD_W;
  localparam int CNT_W  = skhf_pkg::CNT_W;

  // config registers
  logic [VAR_W-1:0] meas_var_q, proc_var_q;

  // captured item
  logic                    func_q, empty_q;
  logic signed [ANG_W-1:0] y_q, gyro_q;

  // filter state
  logic signed [ANG_W-1:0] est_angle_q, est_angle_d;
  logic [VAR_W-1:0]        est_var_q, est_var_d;
  logic                    init_q;

  // divider
  logic [VAR_W:0]   den_q, rem_q, rem_d;
  logic [VAR_W+1:0] rem_sh;
  logic             div_ge;
  logic [K_W-1:0]   quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic [K_W-1:0]   gain, gain_inv;

  // multiplier
  logic signed [OPA_W-1:0]       opa;
  logic signed [OPB_W-1:0]       opb;
  logic signed [OPA_W+OPB_W-1:0] mul_full;
  logic signed [PROD_W-1:0]      prod_q;
  logic [VAR_W:0]                hi_q;

  // post-processing
  logic signed [PROD_W-1:0] rnd24, rnd32;
  logic signed [INC_W-1:0]  inc;
  logic signed [EMIT_W-1:0] deg_r;
  logic signed [ANG_W:0]    diff;
  logic signed [ANG_W-1:0]  ang_new, y_in;
  logic [VAR_W:0]           gvar_sum;
  logic [K_W+VAR_W-K_W+8:0] lo_sum;
  logic [K_W-1:0]           lo_r;
  logic [VAR_W+1:0]         vvar_sum;
  logic [VAR_W-1:0]         gvar_new, vvar_new;

  // output register
  logic                    out_valid_q;
  logic signed [ANG_W-1:0] deg_q;
  logic                    from_gyro_q;

  // config write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_var_q <= skhf_pkg::MEAS_VAR_RST;
      proc_var_q <= skhf_pkg::PROC_VAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        skhf_pkg::REG_MEAS_VAR: meas_var_q <= cfg_data_i;
        skhf_pkg::REG_PROC_VAR: proc_var_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // negated tag angle, most negative value saturates
  assign y_in = (tag_angle_i == skhf_pkg::ANG_MIN) ? skhf_pkg::ANG_MAX : -tag_angle_i;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      empty_q <= (tag_x_i == '0) && (tag_y_i == '0) && (tag_z_i == '0) &&
                 (tag_angle_i == '0);
      y_q     <= y_in;
      gyro_q  <= gyro_delta_i;
    end
  end

  // gain from the divider, zero when both variances are zero
  assign gain     = (den_q == '0) ? '0 : quo_q;
  assign gain_inv = skhf_pkg::ONE_Q24 - gain;
  assign diff     = {y_q[ANG_W-1], y_q} - {est_angle_q[ANG_W-1], est_angle_q};

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.mul_sel)
      skhf_pkg::MUL_GYRO: begin
        opa = {{(OPA_W-ANG_W){gyro_q[ANG_W-1]}}, gyro_q};
        opb = {{(OPB_W-27){1'b0}}, skhf_pkg::DEG2RAD_Q32};
      end
      skhf_pkg::MUL_ANGLE: begin
        opa = {{(OPA_W-ANG_W-1){diff[ANG_W]}}, diff};
        opb = {{(OPB_W-K_W){1'b0}}, gain};
      end
      skhf_pkg::MUL_HI: begin
        opa = {{(OPA_W-16){1'b0}}, est_var_q[VAR_W-1:24]};
        opb = {{(OPB_W-K_W){1'b0}}, gain_inv};
      end
      skhf_pkg::MUL_LO: begin
        opa = {{(OPA_W-24){1'b0}}, est_var_q[23:0]};
        opb = {{(OPB_W-K_W){1'b0}}, gain_inv};
      end
      skhf_pkg::MUL_EMIT: begin
        opa = {{(OPA_W-ANG_W){est_angle_q[ANG_W-1]}}, est_angle_q};
        opb = {{(OPB_W-30){1'b0}}, skhf_pkg::RAD2DEG_Q24};
      end
      default: ;
    endcase
  end

  assign mul_full = opa * opb;

  // product register and saved high partial product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != skhf_pkg::MUL_IDLE) begin
      prod_q <= mul_full[PROD_W-1:0];
    end
    if (cmd_i.hi_save) begin
      hi_q <= prod_q[VAR_W:0];
    end
  end

  // rounding shifts, ties upward
  assign rnd24   = prod_q + $signed(skhf_pkg::RND24);
  assign rnd32   = prod_q + $signed(skhf_pkg::RND32);
  assign inc     = rnd24[PROD_W-1:24];
  assign deg_r   = rnd32[PROD_W-1:32];
  assign ang_new = skhf_pkg::sat_ang({{(SUM_W-ANG_W){est_angle_q[ANG_W-1]}}, est_angle_q} +
                                     {{(SUM_W-INC_W){inc[INC_W-1]}}, inc});

  // variance after a gyro step
  assign gvar_sum = {1'b0, est_var_q} + {1'b0, proc_var_q};
  assign gvar_new = gvar_sum[VAR_W] ? skhf_pkg::VAR_MAX : gvar_sum[VAR_W-1:0];

  // variance after a vision update: hi + round(lo / 2^24)
  assign lo_sum   = prod_q[48:0] + 49'(64'd1 << 23);
  assign lo_r     = lo_sum[48:24];
  assign vvar_sum = {1'b0, hi_q} + {{(VAR_W+2-K_W){1'b0}}, lo_r};
  assign vvar_new = (vvar_sum > {2'b00, skhf_pkg::VAR_MAX}) ? skhf_pkg::VAR_MAX
                                                           : vvar_sum[VAR_W-1:0];

  // filter state next values
  always_comb begin
    est_angle_d = est_angle_q;
    est_var_d   = est_var_q;
    if (cmd_i.init_load) begin
      est_angle_d = y_q;
      est_var_d   = meas_var_q;
    end else if (cmd_i.gyro_upd) begin
      est_angle_d = ang_new;
      est_var_d   = gvar_new;
    end else if (cmd_i.ang_upd) begin
      est_angle_d = ang_new;
    end else if (cmd_i.var_upd) begin
      est_var_d = vvar_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_angle_q <= '0;
      est_var_q   <= '0;
      init_q      <= 1'b0;
    end else begin
      est_angle_q <= est_angle_d;
      est_var_q   <= est_var_d;
      if (cmd_i.init_load) begin
        init_q <= 1'b1;
      end
    end
  end

  // restoring divider step, first step compares without shifting
  assign rem_sh = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign div_ge = rem_sh >= {1'b0, den_q};
  assign rem_d  = div_ge ? 41'(rem_sh - {1'b0, den_q}) : rem_sh[VAR_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q <= {1'b0, est_var_q} + {1'b0, meas_var_q};
      rem_q <= {1'b0, est_var_q};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[K_W-2:0], div_ge};
    end
  end

  // output register, refilled only when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      deg_q       <= skhf_pkg::sat_ang({{(SUM_W-EMIT_W){deg_r[EMIT_W-1]}}, deg_r});
      from_gyro_q <= func_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign filtered_degrees_o = deg_q;
  assign from_gyro_o        = from_gyro_q;

  // status to controller
  assign status_o.is_gyro     = (func_q == skhf_pkg::FUNC_GYRO);
  assign status_o.empty       = empty_q;
  assign status_o.initialised = init_q;
  assign status_o.div_last    = (cnt_q == CNT_W'(skhf_pkg::DIV_STEPS - 1));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

/* design/skhf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skhf_ctrl
// Controller: sequences capture, gain division, multiplies and emission.
// ----------------------------------------------------------------------------
module skhf_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  skhf_pkg::status_t  status_i,
  output skhf_pkg::cmd_t     cmd_o
);

  skhf_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skhf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skhf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = skhf_pkg::ST_DECODE;
      end
      skhf_pkg::ST_DECODE: begin
        if (status_i.is_gyro) begin
          state_d = status_i.initialised ? skhf_pkg::ST_G_MUL : skhf_pkg::ST_IDLE;
        end else if (status_i.empty) begin
          state_d = skhf_pkg::ST_IDLE;
        end else if (!status_i.initialised) begin
          state_d = skhf_pkg::ST_V_INIT;
        end else begin
          state_d = skhf_pkg::ST_DIV_INIT;
        end
      end
      skhf_pkg::ST_G_MUL:    state_d = skhf_pkg::ST_G_UPD;
      skhf_pkg::ST_G_UPD:    state_d = skhf_pkg::ST_E_MUL;
      skhf_pkg::ST_V_INIT:   state_d = skhf_pkg::ST_E_MUL;
      skhf_pkg::ST_DIV_INIT: state_d = skhf_pkg::ST_DIV;
      skhf_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = skhf_pkg::ST_A_MUL;
      end
      skhf_pkg::ST_A_MUL:    state_d = skhf_pkg::ST_A_UPD;
      skhf_pkg::ST_A_UPD:    state_d = skhf_pkg::ST_HI_MUL;
      skhf_pkg::ST_HI_MUL:   state_d = skhf_pkg::ST_LO_MUL;
      skhf_pkg::ST_LO_MUL:   state_d = skhf_pkg::ST_VAR_UPD;
      skhf_pkg::ST_VAR_UPD:  state_d = skhf_pkg::ST_E_MUL;
      skhf_pkg::ST_E_MUL:    state_d = skhf_pkg::ST_EMIT;
      skhf_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = skhf_pkg::ST_IDLE;
      end
      default: state_d = skhf_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = skhf_pkg::MUL_IDLE;
    in_stall_o    = 1'b1;
    unique case (state_q)
      skhf_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      skhf_pkg::ST_DECODE:   ;
      skhf_pkg::ST_G_MUL:    cmd_o.mul_sel   = skhf_pkg::MUL_GYRO;
      skhf_pkg::ST_G_UPD:    cmd_o.gyro_upd  = 1'b1;
      skhf_pkg::ST_V_INIT:   cmd_o.init_load = 1'b1;
      skhf_pkg::ST_DIV_INIT: cmd_o.div_init  = 1'b1;
      skhf_pkg::ST_DIV:      cmd_o.div_step  = 1'b1;
      skhf_pkg::ST_A_MUL:    cmd_o.mul_sel   = skhf_pkg::MUL_ANGLE;
      skhf_pkg::ST_A_UPD:    cmd_o.ang_upd   = 1'b1;
      skhf_pkg::ST_HI_MUL:   cmd_o.mul_sel   = skhf_pkg::MUL_HI;
      skhf_pkg::ST_LO_MUL: begin
        cmd_o.mul_sel = skhf_pkg::MUL_LO;
        cmd_o.hi_save = 1'b1;
      end
      skhf_pkg::ST_VAR_UPD:  cmd_o.var_upd   = 1'b1;
      skhf_pkg::ST_E_MUL:    cmd_o.mul_sel   = skhf_pkg::MUL_EMIT;
      skhf_pkg::ST_EMIT:     cmd_o.out_load  = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* tb/heading_fuser_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heading_fuser_checker
// Watches the item, result and variance-write channels of the heading fuser.
// It tracks the filter state in fixed point, predicts one heading per item
// that updates the filter, and checks every result beat against the oldest
// prediction.
// ---------------------------------------------------------------------------
module heading_fuser_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // item channel
  input  wire                              in_valid_i,
  input  wire                              in_stall_i,
  input  wire                              func_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] tag_x_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] tag_y_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] tag_z_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] tag_angle_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] gyro_delta_i,
  // result channel
  input  wire                              out_valid_i,
  input  wire                              out_stall_i,
  input  wire signed [skhf_pkg::ANG_W-1:0] filtered_degrees_i,
  input  wire                              from_gyro_i,
  // variance writes
  input  wire                              cfg_valid_i,
  input  wire                              cfg_ready_i,
  input  wire [skhf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [skhf_pkg::VAR_W-1:0]        cfg_data_i,
  // status to the test top
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               checked_o
);

  // fixed-point constants of the filter
  localparam longint          DEG_TO_RAD_Q32 = 74961321;   // pi/180 * 2^32
  localparam longint          RAD_TO_DEG_Q24 = 961263669;  // 180/pi * 2^24
  localparam longint unsigned GAIN_ONE       = 64'd16777216;
  localparam longint unsigned VAR_FULL       = 64'hFF_FFFF_FFFF;
  localparam longint unsigned MEAS_VAR_RESET = 64'd281474977;
  localparam longint unsigned PROC_VAR_RESET = 64'd703687442;

  typedef struct packed {
    logic signed [skhf_pkg::ANG_W-1:0] degrees;
    logic                              from_gyro;
  } heading_t;

  // filter state and variance registers
  longint          angle_est;
  longint unsigned var_est;
  bit              have_fix;
  longint unsigned meas_var_q;
  longint unsigned proc_var_q;

  heading_t heading_q[$];
  int       fails;
  int       checked;

  // clamp to the 32 bit signed range
  function automatic longint clamp_angle(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // divide by 2^sh, rounding to nearest with ties upward
  function automatic longint shift_round(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // advance the filter by one item; returns 1 when a heading comes out
  function automatic bit fuse_item(input logic func,
                                   input logic signed [31:0] x,
                                   input logic signed [31:0] y,
                                   input logic signed [31:0] z,
                                   input logic signed [31:0] ang,
                                   input logic signed [31:0] gyro,
                                   output heading_t res);
    longint          meas;
    longint unsigned sum;
    longint unsigned den;
    longint unsigned k;
    longint unsigned keep;
    longint unsigned hi;
    longint unsigned lo;
    res = '0;
    if (func == skhf_pkg::FUNC_GYRO) begin
      // gyro predict, only once a fix exists
      if (!have_fix) return 1'b0;
      angle_est = clamp_angle(angle_est +
                              shift_round(longint'(gyro) * DEG_TO_RAD_Q32, 24));
      sum = var_est + proc_var_q;
      var_est = (sum > VAR_FULL) ? VAR_FULL : sum;
    end else begin
      // all-zero vision beat means no tag in view
      if (x == 0 && y == 0 && z == 0 && ang == 0) return 1'b0;
      meas = clamp_angle(-longint'(ang));
      if (!have_fix) begin
        angle_est = meas;
        var_est = meas_var_q;
        have_fix = 1'b1;
      end else begin
        den = var_est + meas_var_q;
        k = (den != 0) ? (var_est << 24) / den : 64'd0;
        if (k > GAIN_ONE) k = GAIN_ONE;
        angle_est = clamp_angle(angle_est +
                                shift_round((meas - angle_est) * longint'(k), 24));
        keep = GAIN_ONE - k;
        hi = (var_est >> 24) * keep;
        lo = (var_est & 64'hFF_FFFF) * keep;
        var_est = hi + ((lo + 64'h80_0000) >> 24);
        if (var_est > VAR_FULL) var_est = VAR_FULL;
      end
    end
    res.degrees = 32'(clamp_angle(shift_round(angle_est * RAD_TO_DEG_Q24, 32)));
    res.from_gyro = func;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heading_t seen;
    heading_t want;
    if (!rst_ni) begin
      angle_est = 0;
      var_est = 0;
      have_fix = 1'b0;
      meas_var_q = MEAS_VAR_RESET;
      proc_var_q = PROC_VAR_RESET;
      heading_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      // variance register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == skhf_pkg::REG_MEAS_VAR) meas_var_q = cfg_data_i;
        else if (cfg_index_i == skhf_pkg::REG_PROC_VAR) proc_var_q = cfg_data_i;
      end
      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        seen.degrees = filtered_degrees_i;
        seen.from_gyro = from_gyro_i;
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected heading beat: degrees %0d from_gyro %0b",
                   $time, $signed(seen.degrees), seen.from_gyro);
          fails++;
        end else begin
          want = heading_q.pop_front();
          checked++;
          if (seen.degrees !== want.degrees || seen.from_gyro !== want.from_gyro) begin
            $display("%0t: heading mismatch: expected degrees %0d from_gyro %0b, got %0d %0b",
                     $time, $signed(want.degrees), want.from_gyro,
                     $signed(seen.degrees), seen.from_gyro);
            fails++;
          end
        end
      end
      // item beat
      if (in_valid_i && !in_stall_i) begin
        if (fuse_item(func_i, tag_x_i, tag_y_i, tag_z_i, tag_angle_i, gyro_delta_i, want))
          heading_q.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o <= heading_q.size();
    checked_o <= checked;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives vision and gyro items plus variance writes into the heading fuser:
// a directed opening over the corner cases, then random items under three
// idle mixes. The checker beside the block predicts and compares; this top
// only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module testbench;

  localparam int     SETTLE_CYCLES   = 48;
  localparam int     ITEMS_PER_PHASE = 150;
  localparam int     HALF_TURN_Q24   = 52707179;  // pi in radians q.24
  localparam longint TIMEOUT_NS      = 2_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              in_valid_i   = 1'b0;
  wire                               in_stall_o;
  logic                              func_i       = 1'b0;
  logic signed [skhf_pkg::ANG_W-1:0] tag_x_i      = '0;
  logic signed [skhf_pkg::ANG_W-1:0] tag_y_i      = '0;
  logic signed [skhf_pkg::ANG_W-1:0] tag_z_i      = '0;
  logic signed [skhf_pkg::ANG_W-1:0] tag_angle_i  = '0;
  logic signed [skhf_pkg::ANG_W-1:0] gyro_delta_i = '0;
  wire                               out_valid_o;
  logic                              out_stall_i  = 1'b0;
  wire signed [skhf_pkg::ANG_W-1:0]  filtered_degrees_o;
  wire                               from_gyro_o;
  logic                              cfg_valid_i  = 1'b0;
  wire                               cfg_ready_o;
  logic [skhf_pkg::CFG_IDX_W-1:0]    cfg_index_i  = '0;
  logic [skhf_pkg::VAR_W-1:0]        cfg_data_i   = '0;

  int send_idle_pct  = 8;
  int recv_stall_pct = 71;
  int items_sent     = 0;
  int fail_count;
  int pending;
  int checked;

  always #1 clk_i = ~clk_i;

  scalar_kalman_heading_fuser u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .tag_x_i            (tag_x_i),
    .tag_y_i            (tag_y_i),
    .tag_z_i            (tag_z_i),
    .tag_angle_i        (tag_angle_i),
    .gyro_delta_i       (gyro_delta_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .filtered_degrees_o (filtered_degrees_o),
    .from_gyro_o        (from_gyro_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  heading_fuser_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .func_i             (func_i),
    .tag_x_i            (tag_x_i),
    .tag_y_i            (tag_y_i),
    .tag_z_i            (tag_z_i),
    .tag_angle_i        (tag_angle_i),
    .gyro_delta_i       (gyro_delta_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .filtered_degrees_i (filtered_degrees_o),
    .from_gyro_i        (from_gyro_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one item beat, with random idle cycles ahead of it
  task automatic send_beat(input logic func,
                           input logic signed [31:0] x,
                           input logic signed [31:0] y,
                           input logic signed [31:0] z,
                           input logic signed [31:0] ang,
                           input logic signed [31:0] gyro);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    tag_x_i      <= x;
    tag_y_i      <= y;
    tag_z_i      <= z;
    tag_angle_i  <= ang;
    gyro_delta_i <= gyro;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // write both variances back to back
  task automatic program_vars(input logic [skhf_pkg::VAR_W-1:0] meas,
                              input logic [skhf_pkg::VAR_W-1:0] proc);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= skhf_pkg::REG_MEAS_VAR;
    cfg_data_i  <= meas;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= skhf_pkg::REG_PROC_VAR;
    cfg_data_i  <= proc;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every heading, then let a silent item finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord();
    return ($urandom_range(99) < 15) ? 32'sd0 : 32'($urandom());
  endfunction

  // mostly within a half turn, sometimes anything or the extremes
  function automatic logic signed [31:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return int'($urandom_range(2 * HALF_TURN_Q24)) - HALF_TURN_Q24;
    if (sel < 90) return 32'($urandom());
    if (sel < 95) return $urandom_range(1) ? skhf_pkg::ANG_MAX : skhf_pkg::ANG_MIN;
    return 32'sd0;
  endfunction

  // mostly within +-16 degrees per step
  function automatic logic signed [31:0] pick_delta();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return int'($urandom_range(1 << 21)) - (1 << 20);
    if (sel < 90) return 32'($urandom());
    case ($urandom_range(4))
      0: return skhf_pkg::ANG_MAX;
      1: return skhf_pkg::ANG_MIN;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  // variance spread over all magnitudes
  function automatic logic [skhf_pkg::VAR_W-1:0] pick_var();
    logic [skhf_pkg::VAR_W-1:0] v;
    v = 40'({$urandom(), $urandom()});
    return v >> $urandom_range(39);
  endfunction

  // one random item; counts is 0 for a beat the filter ignores
  task automatic send_random(output bit counts);
    int unsigned        sel;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] ang;
    sel = $urandom_range(99);
    if (sel < 10) begin
      send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'($urandom()));
      counts = 1'b0;
    end else if (sel < 55) begin
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      ang = pick_angle();
      send_beat(skhf_pkg::FUNC_VISION, x, y, z, ang, 32'($urandom()));
      counts = (x != 0 || y != 0 || z != 0 || ang != 0);
    end else begin
      send_beat(skhf_pkg::FUNC_GYRO, 32'($urandom()), 32'($urandom()), 32'($urandom()),
                32'($urandom()), pick_delta());
      counts = 1'b1;
    end
  endtask

  task automatic run_random(input int target);
    int done;
    bit counts;
    done = 0;
    while (done < target) begin
      send_random(counts);
      if (counts) done++;
    end
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset variances: silent beats, first fix, saturation of the estimate
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, skhf_pkg::ANG_MAX);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh1234);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, skhf_pkg::ANG_MIN, 32'sd0);
    send_beat(skhf_pkg::FUNC_GYRO, -32'sd1, -32'sd1, -32'sd1, -32'sd1, skhf_pkg::ANG_MAX);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, skhf_pkg::ANG_MIN);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, skhf_pkg::ANG_MIN);
    send_beat(skhf_pkg::FUNC_VISION, skhf_pkg::ANG_MIN, skhf_pkg::ANG_MAX, -32'sd1,
              skhf_pkg::ANG_MAX, 32'sd0);
    // a lone nonzero position makes the beat real
    send_beat(skhf_pkg::FUNC_VISION, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sh8000, 32'sd0, 32'sd0, 32'sd0);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1);
    settle();

    // zero variances: unit gain collapses the variance, then a zero sum gives zero gain
    program_vars('0, '0);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, 32'sd1000000, 32'sd0);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd0, 32'sd0, 32'sd0, -32'sd5000000, 32'sd0);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536);
    settle();

    // full-scale variances: the variance saturates
    program_vars('1, '1);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd131072);
    send_beat(skhf_pkg::FUNC_GYRO, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd65536);
    send_beat(skhf_pkg::FUNC_VISION, 32'sd5, 32'sd0, 32'sd0, 32'sd8388608, 32'sd0);
    settle();

    // random items, sender mostly busy and receiver mostly stalling
    program_vars(40'd1, pick_var());
    run_random(ITEMS_PER_PHASE);
    settle();

    // the other way round
    send_idle_pct  = 71;
    recv_stall_pct = 8;
    program_vars(pick_var() | 40'd1, pick_var());
    run_random(ITEMS_PER_PHASE);
    settle();

    // no idling at all
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_vars(pick_var() | 40'd1, pick_var());
    run_random(ITEMS_PER_PHASE);
    settle();

    $display("run: %0d items accepted, %0d left no heading, %0d headings checked",
             items_sent, items_sent - checked, checked);
    $display("run: idle mixes 8/71, 71/8 and 0/0; variances at reset, zero, full scale, random");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d headings still expected", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
